@@ rtl/core/rc4_pkg.sv @@
// Shared constants and types for the RC4 cipher block.
package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int SBOX_DEPTH    = 256;
    localparam int KEY_BYTES_MAX = 256;
    localparam int KCNT_W        = 9;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [KCNT_W-1:0] kcnt_t;

    // Control sequencer: PRGA steps, then key schedule steps
    typedef enum logic [8:0] {
        ST_IDLE    = 9'b0_0000_0001,
        ST_RD_J    = 9'b0_0000_0010,
        ST_SWAP1   = 9'b0_0000_0100,
        ST_SWAP2   = 9'b0_0000_1000,
        ST_KS_INIT = 9'b0_0001_0000,
        ST_KS_RD   = 9'b0_0010_0000,
        ST_KS_ACC  = 9'b0_0100_0000,
        ST_KS_SW1  = 9'b0_1000_0000,
        ST_KS_SW2  = 9'b1_0000_0000
    } state_t;

endpackage

@@ rtl/core/rc4_stream_cipher.sv @@
// RC4 stream cipher top level: key loading, key schedule and keystream XOR.
//
// Input channel (in_valid/in_ready): one word per handshake. operation = 0
// loads byte_value as the next key byte (bytes past 256 are dropped);
// last_key on such a word starts the key schedule. operation = 1 XORs
// byte_value with the next keystream byte.
// Output channel (out_valid/out_ready): one data_out word per data word,
// none for key words.
// A data word steps through RD_J, SWAP1 and SWAP2: the S-box RAM's one read
// port serialises the reads of S[i], S[j] and S[S[i]+S[j]], its one write
// port the two swap writes. The result enters the output register in SWAP2
// once the slot is free, and the next word is accepted in that same cycle;
// no data word is taken before the last one reaches SWAP2. The key schedule
// after the last key word makes 256 identity writes, then KS_RD, KS_ACC,
// KS_SW1, KS_SW2 per swap over 256 entries; no word is accepted meanwhile.
// Reset clears the indices, the key count and the S-box valid bits, so the
// S-box reads as zeros and data passes through unchanged until a key is set.
// When the receiver stalls, the finished word waits in the output register;
// the block holds its third step, and accepts nothing, until the slot frees.
module rc4_stream_cipher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] byte_value,
    input  logic       last_key,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_out
);

    localparam rc4_pkg::kcnt_t KEY_MAX = rc4_pkg::KCNT_W'(rc4_pkg::KEY_BYTES_MAX);
    localparam rc4_pkg::byte_t IDX_LAST = rc4_pkg::BYTE_W'(rc4_pkg::SBOX_DEPTH - 1);

    rc4_pkg::state_t state_reg, state_next;

    rc4_pkg::byte_t  i_reg, i_next;
    rc4_pkg::byte_t  j_reg, j_next;
    rc4_pkg::kcnt_t  key_count_reg, key_count_next;
    rc4_pkg::byte_t  k_reg, k_next;
    rc4_pkg::byte_t  kidx_reg, kidx_next;
    logic            out_valid_reg, out_valid_next;
    logic [rc4_pkg::SBOX_DEPTH-1:0] vld_reg;
    logic            vld_rd_reg;
    logic            fwd_hit_reg;

    // datapath registers
    rc4_pkg::byte_t  data_out_reg, data_out_next;
    rc4_pkg::byte_t  b_reg;
    rc4_pkg::byte_t  si_reg, si_next;
    rc4_pkg::byte_t  t_reg, t_next;
    rc4_pkg::byte_t  acc_reg, acc_next;
    rc4_pkg::byte_t  sk_reg, sk_next;
    rc4_pkg::byte_t  fwd_data_reg;

    // S-box port
    logic            s_we, s_re;
    rc4_pkg::byte_t  s_waddr, s_wdata, s_raddr, s_rdata, s_rd;

    // key store port
    logic            k_we, k_re;
    rc4_pkg::byte_t  k_rdata;

    logic out_free, in_acc, data_acc, key_acc, key_room;
    rc4_pkg::byte_t ks;

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::SBOX_DEPTH)
    ) u_sbox (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::KEY_BYTES_MAX)
    ) u_key_store (
        .clk   (clk),
        .we    (k_we),
        .waddr (key_count_reg[rc4_pkg::BYTE_W-1:0]),
        .wdata (byte_value),
        .re    (k_re),
        .raddr (kidx_reg),
        .rdata (k_rdata)
    );

    // S-box read value: forwarded write, else stored entry, else reset zero
    assign s_rd = fwd_hit_reg ? fwd_data_reg : (vld_rd_reg ? s_rdata : '0);

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == rc4_pkg::ST_IDLE)
                   || ((state_reg == rc4_pkg::ST_SWAP2) && out_free);
    assign in_acc   = in_valid && in_ready;
    assign data_acc = in_acc && operation;
    assign key_acc  = in_acc && !operation;
    assign key_room = key_count_reg < KEY_MAX;

    assign k_we = key_acc && key_room;
    assign k_re = (state_reg == rc4_pkg::ST_KS_RD);

    // after the swap S[j] holds the old S[i]
    assign ks = (t_reg == j_reg) ? si_reg : s_rd;

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        key_count_next = key_count_reg;
        k_next         = k_reg;
        kidx_next      = kidx_reg;
        out_valid_next = out_valid_reg;
        data_out_next  = data_out_reg;
        si_next        = si_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        sk_next        = sk_reg;
        s_we           = 1'b0;
        s_waddr        = '0;
        s_wdata        = '0;
        s_re           = 1'b0;
        s_raddr        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (key_acc && key_room)
        begin
            key_count_next = key_count_reg + 1'b1;
        end

        if (data_acc)
        begin
            i_next  = i_reg + 1'b1;
            s_re    = 1'b1;
            s_raddr = i_reg + 1'b1;
        end

        unique case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                if (data_acc)
                begin
                    state_next = rc4_pkg::ST_RD_J;
                end
                else if (key_acc && last_key)
                begin
                    state_next = rc4_pkg::ST_KS_INIT;
                    k_next     = '0;
                end
            end
            rc4_pkg::ST_RD_J:
            begin
                si_next    = s_rd;
                j_next     = j_reg + s_rd;
                s_re       = 1'b1;
                s_raddr    = j_reg + s_rd;
                state_next = rc4_pkg::ST_SWAP1;
            end
            rc4_pkg::ST_SWAP1:
            begin
                s_we       = 1'b1;
                s_waddr    = i_reg;
                s_wdata    = s_rd;
                t_next     = si_reg + s_rd;
                s_re       = 1'b1;
                s_raddr    = si_reg + s_rd;
                state_next = rc4_pkg::ST_SWAP2;
            end
            rc4_pkg::ST_SWAP2:
            begin
                s_we    = 1'b1;
                s_waddr = j_reg;
                s_wdata = si_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    data_out_next  = b_reg ^ ks;
                    if (data_acc)
                    begin
                        state_next = rc4_pkg::ST_RD_J;
                    end
                    else if (key_acc && last_key)
                    begin
                        state_next = rc4_pkg::ST_KS_INIT;
                        k_next     = '0;
                    end
                    else
                    begin
                        state_next = rc4_pkg::ST_IDLE;
                    end
                end
            end
            rc4_pkg::ST_KS_INIT:
            begin
                s_we    = 1'b1;
                s_waddr = k_reg;
                s_wdata = k_reg;
                k_next  = k_reg + 1'b1;
                if (k_reg == IDX_LAST)
                begin
                    acc_next   = '0;
                    kidx_next  = '0;
                    state_next = rc4_pkg::ST_KS_RD;
                end
            end
            rc4_pkg::ST_KS_RD:
            begin
                s_re       = 1'b1;
                s_raddr    = k_reg;
                state_next = rc4_pkg::ST_KS_ACC;
            end
            rc4_pkg::ST_KS_ACC:
            begin
                sk_next    = s_rd;
                acc_next   = acc_reg + s_rd + k_rdata;
                s_re       = 1'b1;
                s_raddr    = acc_reg + s_rd + k_rdata;
                state_next = rc4_pkg::ST_KS_SW1;
            end
            rc4_pkg::ST_KS_SW1:
            begin
                s_we       = 1'b1;
                s_waddr    = k_reg;
                s_wdata    = s_rd;
                state_next = rc4_pkg::ST_KS_SW2;
            end
            rc4_pkg::ST_KS_SW2:
            begin
                s_we    = 1'b1;
                s_waddr = acc_reg;
                s_wdata = sk_reg;
                k_next  = k_reg + 1'b1;
                // wrap the key index at the key length
                if (({1'b0, kidx_reg} + 1'b1) >= key_count_reg)
                begin
                    kidx_next = '0;
                end
                else
                begin
                    kidx_next = kidx_reg + 1'b1;
                end
                if (k_reg == IDX_LAST)
                begin
                    i_next         = '0;
                    j_next         = '0;
                    key_count_next = '0;
                    state_next     = rc4_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4_pkg::ST_KS_RD;
                end
            end
            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            key_count_reg <= '0;
            k_reg         <= '0;
            kidx_reg      <= '0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            vld_rd_reg    <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            key_count_reg <= key_count_next;
            k_reg         <= k_next;
            kidx_reg      <= kidx_next;
            out_valid_reg <= out_valid_next;
            if (s_we)
            begin
                vld_reg[s_waddr] <= 1'b1;
            end
            if (s_re)
            begin
                vld_rd_reg  <= vld_reg[s_raddr];
                fwd_hit_reg <= s_we && (s_waddr == s_raddr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_out_reg <= data_out_next;
        si_reg       <= si_next;
        t_reg        <= t_next;
        acc_reg      <= acc_next;
        sk_reg       <= sk_next;
        if (data_acc)
        begin
            b_reg <= byte_value;
        end
        if (s_re)
        begin
            fwd_data_reg <= s_wdata;
        end
    end

`ifndef ASSERT_OFF
    a_out_from_swap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rc4_pkg::ST_SWAP2))
        else $error("output word raised outside the final PRGA step");

    a_no_accept_in_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_KS_INIT || state_reg == rc4_pkg::ST_KS_RD
         || state_reg == rc4_pkg::ST_KS_ACC || state_reg == rc4_pkg::ST_KS_SW1
         || state_reg == rc4_pkg::ST_KS_SW2) |-> !in_ready)
        else $error("input accepted during key schedule");

    a_key_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KEY_MAX)
        else $error("key count beyond maximum");

    a_schedule_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_KS_SW2 && k_reg == IDX_LAST)
        |=> (i_reg == '0 && j_reg == '0 && key_count_reg == '0))
        else $error("indices or key count not cleared after schedule");

    a_swap_holds_out_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_SWAP2 && out_valid_reg && !out_ready)
        |=> (state_reg == rc4_pkg::ST_SWAP2 && $stable(data_out_reg)))
        else $error("PRGA step left while output slot full");
`endif

endmodule

@@ rtl/core/rc4_ram.sv @@
// Generic simple dual-port RAM with registered read (old data on collision).
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ tb/sv/tb_rc4_stream_cipher.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for rc4_stream_cipher: directed table, random key/data traffic.
module tb_rc4_stream_cipher;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    localparam int ITEM_TARGET   = 850;
    localparam int STALL_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 1400;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        logic           op;
        rc4_pkg::byte_t value;
        logic           last;
        logic           pinned;
        rc4_pkg::byte_t want;
    } stim_row_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic       operation  = 1'b0;
    logic [7:0] byte_value = 8'h00;
    logic       last_key   = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] data_out;

    // Cipher state as the block should hold it
    rc4_pkg::byte_t sbox_m      [rc4_pkg::SBOX_DEPTH];
    rc4_pkg::byte_t key_store_m [rc4_pkg::KEY_BYTES_MAX];
    rc4_pkg::kcnt_t key_len;
    rc4_pkg::byte_t idx_i;
    rc4_pkg::byte_t idx_j;

    rc4_pkg::byte_t expected_bytes [$];
    int    mismatches  = 0;
    int    words_sent  = 0;
    bit    calm        = 1'b0;

    // Plain data before the first key schedule must pass through; everything else goes to the predictor.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_DATA, 8'h00, 1'b0, 1'b1, 8'h00},
        '{OP_DATA, 8'hFF, 1'b1, 1'b1, 8'hFF},
        '{OP_DATA, 8'h5A, 1'b0, 1'b1, 8'h5A},
        '{OP_KEY,  8'hFF, 1'b0, 1'b0, 8'h00},
        '{OP_DATA, 8'h81, 1'b0, 1'b1, 8'h81},
        '{OP_KEY,  8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_KEY,  8'h80, 1'b1, 1'b0, 8'h00},
        '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_DATA, 8'hFF, 1'b0, 1'b0, 8'h00},
        '{OP_DATA, 8'h01, 1'b0, 1'b0, 8'h00},
        '{OP_KEY,  8'h01, 1'b1, 1'b0, 8'h00},
        '{OP_DATA, 8'h80, 1'b0, 1'b0, 8'h00},
        '{OP_DATA, 8'h7F, 1'b0, 1'b0, 8'h00},
        '{OP_KEY,  8'hFF, 1'b1, 1'b0, 8'h00},
        '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
        '{OP_DATA, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{OP_KEY,  8'h4B, 1'b0, 1'b0, 8'h00},
        '{OP_KEY,  8'h65, 1'b0, 1'b0, 8'h00},
        '{OP_KEY,  8'h79, 1'b1, 1'b0, 8'h00},
        '{OP_DATA, 8'h50, 1'b0, 1'b0, 8'h00},
        '{OP_DATA, 8'h6C, 1'b0, 1'b0, 8'h00},
        '{OP_DATA, 8'h61, 1'b0, 1'b0, 8'h00},
        '{OP_DATA, 8'h69, 1'b0, 1'b0, 8'h00},
        '{OP_DATA, 8'h6E, 1'b0, 1'b0, 8'h00}
    };

    rc4_stream_cipher uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .byte_value (byte_value),
        .last_key   (last_key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_out   (data_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Advance the cipher state by one accepted word and queue its output byte
    task automatic apply_word(input logic op, input rc4_pkg::byte_t value, input logic last);
        rc4_pkg::byte_t acc;
        rc4_pkg::byte_t tmp;
        int    n;
        int    k;
        if (op == OP_KEY)
        begin
            if (key_len < rc4_pkg::KEY_BYTES_MAX)
            begin
                key_store_m[key_len[7:0]] = value;
                key_len++;
            end
            if (last)
            begin
                n = (key_len == 0) ? 1 : int'(key_len);
                for (k = 0; k < rc4_pkg::SBOX_DEPTH; k++)
                    sbox_m[k] = rc4_pkg::byte_t'(k);
                acc = '0;
                for (k = 0; k < rc4_pkg::SBOX_DEPTH; k++)
                begin
                    acc = acc + sbox_m[k] + key_store_m[k % n];
                    tmp = sbox_m[k];
                    sbox_m[k] = sbox_m[acc];
                    sbox_m[acc] = tmp;
                end
                idx_i   = '0;
                idx_j   = '0;
                key_len = '0;
            end
        end
        else
        begin
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + sbox_m[idx_i];
            tmp = sbox_m[idx_i];
            sbox_m[idx_i] = sbox_m[idx_j];
            sbox_m[idx_j] = tmp;
            expected_bytes.push_back(
                value ^ sbox_m[rc4_pkg::byte_t'(sbox_m[idx_i] + sbox_m[idx_j])]);
        end
    endtask

    task automatic send_word(input logic op, input rc4_pkg::byte_t value, input logic last,
                             input logic pinned, input rc4_pkg::byte_t want);
        if (!calm && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 36);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        byte_value <= value;
        last_key   <= last;
        do @(posedge clk); while (!in_ready);
        apply_word(op, value, last);
        if (pinned && op == OP_DATA)
            expected_bytes[expected_bytes.size() - 1] = want;
        words_sent++;
    endtask

    task automatic send_key(input int len);
        int n;
        for (n = 1; n <= len; n++)
            send_word(OP_KEY, rc4_pkg::byte_t'($urandom_range(0, 255)), n == len, 1'b0, '0);
    endtask

    task automatic send_data(input int count, input bit noisy);
        int n;
        for (n = 0; n < count; n++)
            send_word(OP_DATA, rc4_pkg::byte_t'($urandom_range(0, 255)),
                      noisy ? logic'($urandom_range(0, 1)) : 1'b0, 1'b0, '0);
    endtask

    // Hold the sender until every queued byte has come out
    task automatic wait_for_results;
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_bytes.size() != 0);
    endtask

    always @(posedge clk)
    begin
        out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected data_out %02h", $realtime, data_out);
            end
            else
            begin
                if (data_out !== expected_bytes[0])
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: data_out mismatch: expected %02h, got %02h",
                                 $realtime, expected_bytes[0], data_out);
                end
                void'(expected_bytes.pop_front());
            end
        end
    end

    // Abort when neither channel moves a word for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("rc4_stream_cipher regression: fail");
        $finish;
    end

    initial
    begin
        int row;
        int round_no;
        int long_keys;
        int pick;
        int n;
        int parts;
        for (n = 0; n < rc4_pkg::SBOX_DEPTH; n++)
        begin
            sbox_m[n]      = '0;
            key_store_m[n] = '0;
        end
        key_len = '0;
        idx_i   = '0;
        idx_j   = '0;
        round_no  = 0;
        long_keys = 0;

        @(posedge clk);
        while (!rst_n) @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
            send_word(directed_rows[row].op, directed_rows[row].value, directed_rows[row].last,
                      directed_rows[row].pinned, directed_rows[row].want);
        wait_for_results();

        while (words_sent < ITEM_TARGET)
        begin
            calm = (words_sent >= 350 && words_sent < 520);
            pick = $urandom_range(0, 99);
            if (round_no == 3 || (pick < 3 && long_keys < 2))
            begin
                // overlong key: bytes past the limit drop, last may land on a dropped byte
                send_key(rc4_pkg::KEY_BYTES_MAX + $urandom_range(0, 8));
                long_keys++;
                send_data($urandom_range(10, 30), 1'b0);
            end
            else if (pick < 65)
            begin
                // key of 1 to 16 bytes, optionally lengthened by 16 more random bytes
                send_key($urandom_range(1, 16) + ($urandom_range(0, 1) ? 16 : 0));
                send_data($urandom_range(8, 40), 1'b0);
            end
            else if (pick < 80)
                send_data($urandom_range(1, 20), 1'b1);
            else
            begin
                // partial key interleaved with data; the next schedule picks it up
                parts = $urandom_range(1, 6);
                for (n = 0; n < parts; n++)
                begin
                    if ($urandom_range(0, 1))
                        send_word(OP_KEY, rc4_pkg::byte_t'($urandom_range(0, 255)),
                                  1'b0, 1'b0, '0);
                    else
                        send_data($urandom_range(1, 4), 1'b1);
                end
            end
            if ($urandom_range(0, 99) < 8)
                wait_for_results();
            round_no++;
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        do @(posedge clk); while (expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("rc4_stream_cipher regression: pass");
        else
            $display("rc4_stream_cipher regression: fail");
        $finish;
    end

endmodule

@@ rc4_stream_cipher.f @@
rtl/core/rc4_pkg.sv
rtl/core/rc4_ram.sv
rtl/core/rc4_stream_cipher.sv
tb/sv/tb_rc4_stream_cipher.sv
